// ===== sv/cgs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cgs_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned GearW   = 5;
  localparam int unsigned PassW   = 9;
  localparam int unsigned TickW   = 10;
  localparam int unsigned LimitW  = 8;
  localparam int unsigned FrontW  = 11;
  localparam int unsigned StepsW  = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 10;

  localparam logic [FrontW-1:0] FrontPosMid  = 11'd1100;
  localparam logic [FrontW-1:0] FrontPosHigh = 11'd1800;
  localparam logic [StepsW-1:0] StepsUp      = 10'd500;
  localparam logic [StepsW-1:0] StepsDown    = 10'd1000;
  localparam logic [PassW-1:0]  PassMax      = 9'd511;

  localparam logic [SampleW-1:0] LowThresholdRst  = 10'd200;
  localparam logic [SampleW-1:0] HighThresholdRst = 10'd700;
  localparam logic [TickW-1:0]   WindowTicksRst   = 10'd300;
  localparam logic [LimitW-1:0]  UpLimitRst       = 8'd5;
  localparam logic [LimitW-1:0]  DownBelowRst     = 8'd3;
  localparam logic [LimitW-1:0]  DownMinRst       = 8'd1;

  typedef enum logic [1:0] {
    SHIFT_NONE = 2'd0,
    SHIFT_UP   = 2'd1,
    SHIFT_DOWN = 2'd2
  } shift_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_THRESHOLD  = 3'd0,
    CFG_HIGH_THRESHOLD = 3'd1,
    CFG_WINDOW_TICKS   = 3'd2,
    CFG_UP_LIMIT       = 3'd3,
    CFG_DOWN_BELOW     = 3'd4,
    CFG_DOWN_MIN       = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] low_threshold;
    logic [SampleW-1:0] high_threshold;
    logic [TickW-1:0]   window_ticks;
    logic [LimitW-1:0]  up_limit;
    logic [LimitW-1:0]  down_below;
    logic [LimitW-1:0]  down_min;
  } cgs_cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic [SampleW-1:0] sample;
  } cgs_item_t;

  // Packed so that shift lands in the lowest bits.
  typedef struct packed {
    logic              display_update;
    logic              indicator;
    logic [StepsW-1:0] rear_steps;
    logic [FrontW-1:0] front_position;
    logic [GearW-1:0]  gear;
    shift_e            shift;
  } cgs_result_t;

  function automatic logic [FrontW-1:0] front_pos(input logic [GearW-1:0] gear);
    logic [FrontW-1:0] pos;
    pos = '0;
    unique case (gear)
      5'd2, 5'd5, 5'd8, 5'd11, 5'd12, 5'd15:             pos = FrontPosMid;
      5'd6, 5'd10, 5'd13, 5'd14, 5'd16, 5'd17:           pos = FrontPosHigh;
      default:                                           pos = '0;
    endcase
    return pos;
  endfunction

endpackage
`default_nettype wire

// ===== sv/cgs_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cgs_cfg_regs
  import cgs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  output cgs_cfg_t                cfg_o
);

  cgs_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LOW_THRESHOLD:  cfg_d.low_threshold  = cfg_data_i;
        CFG_HIGH_THRESHOLD: cfg_d.high_threshold = cfg_data_i;
        CFG_WINDOW_TICKS:   cfg_d.window_ticks   = cfg_data_i;
        CFG_UP_LIMIT:       cfg_d.up_limit       = cfg_data_i[LimitW-1:0];
        CFG_DOWN_BELOW:     cfg_d.down_below     = cfg_data_i[LimitW-1:0];
        CFG_DOWN_MIN:       cfg_d.down_min       = cfg_data_i[LimitW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold  <= LowThresholdRst;
      cfg_q.high_threshold <= HighThresholdRst;
      cfg_q.window_ticks   <= WindowTicksRst;
      cfg_q.up_limit       <= UpLimitRst;
      cfg_q.down_below     <= DownBelowRst;
      cfg_q.down_min       <= DownMinRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== sv/cgs_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cgs_core
  import cgs_pkg::*;
#(
  parameter int unsigned NUM_GEARS = 18
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      advance_i,
  input  wire cgs_item_t item_i,
  input  wire cgs_cfg_t  cfg_i,
  output cgs_result_t    result_o
);

  localparam logic [GearW-1:0] GearMax = GearW'(NUM_GEARS - 1);

  logic             armed_q, armed_d;
  logic             ind_q, ind_d;
  logic [PassW-1:0] pass_q, pass_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [GearW-1:0] gear_q, gear_d;

  logic [TickW:0]   tick_next;
  logic             eval;
  logic             up_req;
  logic             down_req;

  assign tick_next = {1'b0, tick_q} + 1'b1;
  assign eval      = (item_i.kind == KIND_TICK) && (tick_next > {1'b0, cfg_i.window_ticks});
  assign up_req    = pass_q > {1'b0, cfg_i.up_limit};
  assign down_req  = (pass_q < {1'b0, cfg_i.down_below}) && (pass_q >= {1'b0, cfg_i.down_min});

  always_comb begin
    armed_d  = armed_q;
    ind_d    = ind_q;
    pass_d   = pass_q;
    tick_d   = tick_q;
    gear_d   = gear_q;
    result_o = '{display_update: 1'b0, indicator: 1'b0, rear_steps: '0,
                 front_position: '0, gear: '0, shift: SHIFT_NONE};
    if (item_i.kind == KIND_SAMPLE) begin
      if (armed_q && (item_i.sample <= cfg_i.low_threshold)) begin
        if (pass_q != PassMax) begin
          pass_d = pass_q + 1'b1;
        end
        armed_d = 1'b0;
        ind_d   = 1'b1;
      end else if (!armed_q && (item_i.sample >= cfg_i.high_threshold)) begin
        armed_d = 1'b1;
        ind_d   = 1'b0;
      end
    end else if (eval) begin
      if (up_req) begin
        result_o.display_update = 1'b1;
        if (gear_q != GearMax) begin
          gear_d                  = gear_q + 1'b1;
          result_o.shift          = SHIFT_UP;
          result_o.front_position = front_pos(gear_d);
          result_o.rear_steps     = StepsUp;
        end
      end else if (down_req && (gear_q != '0)) begin
        gear_d                  = gear_q - 1'b1;
        result_o.shift          = SHIFT_DOWN;
        result_o.front_position = front_pos(gear_d);
        result_o.rear_steps     = StepsDown;
        result_o.display_update = 1'b1;
      end
      tick_d = '0;
      pass_d = '0;
    end else begin
      tick_d = tick_next[TickW-1:0];
    end
    result_o.gear      = gear_d;
    result_o.indicator = ind_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b1;
      ind_q   <= 1'b1;
      pass_q  <= '0;
      tick_q  <= '0;
      gear_q  <= '0;
    end else if (advance_i) begin
      armed_q <= armed_d;
      ind_q   <= ind_d;
      pass_q  <= pass_d;
      tick_q  <= tick_d;
      gear_q  <= gear_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_gear_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gear_q <= GearMax)
    else $error("gear index above top gear");

  a_eval_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && eval |=> (pass_q == '0) && (tick_q == '0))
    else $error("counters not cleared after evaluation");

  a_sample_keeps_gear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (item_i.kind == KIND_SAMPLE) |=> $stable(gear_q))
    else $error("gear moved on a sample");

  a_down_displays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.shift == SHIFT_DOWN |-> result_o.display_update)
    else $error("downshift without display update");
`endif

endmodule
`default_nettype wire

// ===== sv/cadence_gear_shift_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Cadence gear shift controller.
// Input stream: s_axis_tuser carries the item kind (0 ADC sample, 1 timer tick),
// s_axis_tdata[9:0] the ADC sample. Every item yields exactly one result on the
// master stream: shift code, gear, front position, rear steps, indicator level
// and display update flag, packed in m_axis_tdata from bit 0 up.
// Configuration: cfg_valid_i with cfg_index_i selects one of six registers
// (low/high threshold, window ticks, up limit, down below, down min); writes
// complete when offered; users make them while no item is in flight (unchecked).
// Flow: an accepted item is registered in item_q, processed by the detector,
// window and gear logic, and its result is registered in out_q and shown on
// m_axis. One item per cycle is sustained while m_axis_tready stays high; the
// input register and the result register form a two-deep pipeline.
// Reset: registers return to their default values, the detector is armed, the
// indicator is high, counters and gear are zero, both streams are empty.
// Stall: while m_axis_tready is low the result is held, the pipeline fills,
// and s_axis_tready drops once both stages hold an item.
module cadence_gear_shift_controller
  import cgs_pkg::*;
#(
  parameter int unsigned NUM_GEARS = 18
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [15:0]        s_axis_tdata,  // [9:0] sample
  input  wire logic               s_axis_tuser,  // [0] kind
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [1:0] shift, [6:2] gear, [17:7] front_position, [27:18] rear_steps,
  // [28] indicator, [29] display_update
  output logic [31:0]             m_axis_tdata,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  cgs_cfg_t    cfg;
  cgs_item_t   item_q;
  cgs_result_t result;
  cgs_result_t out_q;
  logic        in_valid_q, in_valid_d;
  logic        out_valid_q, out_valid_d;
  logic        out_ready;
  logic        advance;
  logic        s_accept;

  cgs_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cgs_core #(
    .NUM_GEARS (NUM_GEARS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : ((m_axis_tready) ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_q.kind   <= kind_e'(s_axis_tuser);
      item_q.sample <= s_axis_tdata[SampleW-1:0];
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

`ifndef NO_ASSERTIONS
  a_result_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("processed item produced no result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> !out_valid_q || m_axis_tready)
    else $error("pending result overwritten");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("buffered item dropped");
`endif

endmodule
`default_nettype wire

// ===== sim/cgs_result_checker.sv =====
`timescale 1ns / 1ps
module cgs_result_checker
  import cgs_pkg::*;
#(
  parameter int unsigned NUM_GEARS = 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [15:0]        s_tdata_i,
  input  logic               s_tuser_i,
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [31:0]        m_tdata_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int unsigned        owed_o,
  output int unsigned        errors_o
);

  localparam int unsigned TableLen = 18;
  localparam logic [FrontW-1:0] NoFront = '0;
  // one bit per gear, gear 0 in bit 0
  localparam logic [TableLen-1:0] MidGears  = 18'b001001100100100100;
  localparam logic [TableLen-1:0] HighGears = 18'b110110010001000000;

  cgs_result_t        owed_results[$];
  logic               det_armed;
  logic               ind_level;
  logic [PassW-1:0]   passes;
  logic [TickW-1:0]   ticks;
  logic [GearW-1:0]   gear_now;
  logic [SampleW-1:0] thr_low;
  logic [SampleW-1:0] thr_high;
  logic [TickW-1:0]   win_len;
  logic [LimitW-1:0]  lim_up;
  logic [LimitW-1:0]  lim_below;
  logic [LimitW-1:0]  lim_min;
  int unsigned        errors;

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    errors++;
    $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic cgs_result_t step_gearbox(input kind_e kind,
                                               input logic [SampleW-1:0] sample);
    cgs_result_t res;
    logic [TickW:0] next_tick;
    res = '0;
    res.shift = SHIFT_NONE;
    if (kind == KIND_SAMPLE) begin
      if (det_armed && sample <= thr_low) begin
        if (passes != PassMax) passes = passes + 1'b1;
        det_armed = 1'b0;
        ind_level = 1'b1;
      end else if (!det_armed && sample >= thr_high) begin
        det_armed = 1'b1;
        ind_level = 1'b0;
      end
    end else begin
      next_tick = {1'b0, ticks} + 1'b1;
      if (next_tick > win_len) begin
        // upshift takes priority when both requests hold
        if (passes > lim_up) begin
          res.display_update = 1'b1;
          if (gear_now + 1 < NUM_GEARS) begin
            gear_now = gear_now + 1'b1;
            res.shift = SHIFT_UP;
            res.rear_steps = StepsUp;
          end
        end else if (passes < lim_below && passes >= lim_min) begin
          if (gear_now != '0) begin
            gear_now = gear_now - 1'b1;
            res.shift = SHIFT_DOWN;
            res.rear_steps = StepsDown;
            res.display_update = 1'b1;
          end
        end
        if (res.shift != SHIFT_NONE && gear_now < TableLen) begin
          res.front_position = MidGears[gear_now]  ? FrontPosMid  :
                               HighGears[gear_now] ? FrontPosHigh : NoFront;
        end
        ticks = '0;
        passes = '0;
      end else begin
        ticks = next_tick[TickW-1:0];
      end
    end
    res.gear = gear_now;
    res.indicator = ind_level;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cgs_result_t got;
    cgs_result_t want;
    if (!rst_ni) begin
      det_armed = 1'b1;
      ind_level = 1'b1;
      passes    = '0;
      ticks     = '0;
      gear_now  = '0;
      thr_low   = LowThresholdRst;
      thr_high  = HighThresholdRst;
      win_len   = WindowTicksRst;
      lim_up    = UpLimitRst;
      lim_below = DownBelowRst;
      lim_min   = DownMinRst;
      errors    = 0;
      owed_results.delete();
      owed_o   <= 0;
      errors_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = cgs_result_t'(m_tdata_i[$bits(cgs_result_t)-1:0]);
        if (owed_results.size() == 0) begin
          flag_mismatch("result with nothing pending, tdata", m_tdata_i, 0);
        end else begin
          want = owed_results.pop_front();
          if (got.shift != want.shift) flag_mismatch("shift", got.shift, want.shift);
          if (got.gear != want.gear) flag_mismatch("gear", got.gear, want.gear);
          if (got.front_position != want.front_position)
            flag_mismatch("front_position", got.front_position, want.front_position);
          if (got.rear_steps != want.rear_steps)
            flag_mismatch("rear_steps", got.rear_steps, want.rear_steps);
          if (got.indicator != want.indicator)
            flag_mismatch("indicator", got.indicator, want.indicator);
          if (got.display_update != want.display_update)
            flag_mismatch("display_update", got.display_update, want.display_update);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        owed_results.push_back(step_gearbox(kind_e'(s_tuser_i), s_tdata_i[SampleW-1:0]));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LOW_THRESHOLD:  thr_low   = cfg_data_i;
          CFG_HIGH_THRESHOLD: thr_high  = cfg_data_i;
          CFG_WINDOW_TICKS:   win_len   = cfg_data_i;
          CFG_UP_LIMIT:       lim_up    = cfg_data_i[LimitW-1:0];
          CFG_DOWN_BELOW:     lim_below = cfg_data_i[LimitW-1:0];
          CFG_DOWN_MIN:       lim_min   = cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end
      owed_o   <= owed_results.size();
      errors_o <= errors;
    end
  end

endmodule

// ===== sim/tb_cadence_gear_shift_controller.sv =====
`timescale 1ns / 1ps
module tb_cadence_gear_shift_controller;
  import cgs_pkg::*;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;
  localparam logic [SampleW-1:0] SampleMax  = '1;
  localparam logic [SampleW-1:0] SampleMin  = '0;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata  = '0;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [CfgW-1:0]    cfg_data_i    = '0;

  int unsigned        results_owed;
  int unsigned        mismatches;
  int unsigned        idle_cycles   = 0;
  int unsigned        stall_phase   = 0;
  int unsigned        burst_left    = 0;
  bit                 tx_on         = 1'b0;
  logic [SampleW-1:0] low_now       = LowThresholdRst;
  logic [SampleW-1:0] high_now      = HighThresholdRst;

  cadence_gear_shift_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  cgs_result_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .owed_o      (results_owed),
    .errors_o    (mismatches)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    case (stall_phase[9:8])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_phase[3:0] > 4'd11);
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk_i); while (idle_cycles < IdleLimit);
    $display("Regression FAIL");
    $finish;
  end

  task automatic lower_valid();
    if (tx_on) begin
      s_axis_tvalid <= 1'b0;
      tx_on = 1'b0;
    end
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        lower_valid();
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_item(input kind_e kind, input logic [SampleW-1:0] sample);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(16 - SampleW){1'b0}}, sample};
    tx_on = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pace();
  endtask

  task automatic drain();
    lower_valid();
    do @(posedge clk_i); while (results_owed != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (index)
      CFG_LOW_THRESHOLD:  low_now  = value;
      CFG_HIGH_THRESHOLD: high_now = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(input int unsigned low, input int unsigned high,
                               input int unsigned window, input int unsigned up,
                               input int unsigned below, input int unsigned least);
    write_reg(CFG_LOW_THRESHOLD, CfgW'(low));
    write_reg(CFG_HIGH_THRESHOLD, CfgW'(high));
    write_reg(CFG_WINDOW_TICKS, CfgW'(window));
    write_reg(CFG_UP_LIMIT, CfgW'(up));
    write_reg(CFG_DOWN_BELOW, CfgW'(below));
    write_reg(CFG_DOWN_MIN, CfgW'(least));
  endtask

  // bias samples towards threshold crossings so the detector keeps counting
  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2: return SampleW'($urandom_range(0, low_now));
      3, 4, 5: return SampleW'($urandom_range(high_now, SampleMax));
      6:       return SampleW'(low_now + $urandom_range(0, 1));
      7:       return SampleW'(high_now - $urandom_range(0, 1));
      default: return SampleW'($urandom_range(0, SampleMax));
    endcase
  endfunction

  task automatic run_phase(input int unsigned count, input int unsigned tick_odds);
    repeat (count) begin
      if ($urandom_range(1, tick_odds) == 1) begin
        send_item(KIND_TICK, SampleW'($urandom_range(0, SampleMax)));
      end else begin
        send_item(KIND_SAMPLE, pick_sample());
      end
      if ($urandom_range(0, 199) == 0) drain();
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(KIND_SAMPLE, SampleMax);
    send_item(KIND_SAMPLE, 10'd201);
    send_item(KIND_SAMPLE, 10'd200);
    send_item(KIND_SAMPLE, SampleMin);
    send_item(KIND_SAMPLE, 10'd699);
    send_item(KIND_SAMPLE, 10'd700);
    send_item(KIND_TICK, SampleMax);
    drain();

    load_settings(32'(SampleMin), 32'(SampleMax), 0, 2, 2, 1);
    write_reg(CfgSpareLo, '1);
    write_reg(CfgSpareHi, '1);
    send_item(KIND_TICK, SampleMin);
    send_item(KIND_SAMPLE, 10'd1);
    send_item(KIND_SAMPLE, SampleMin);
    send_item(KIND_SAMPLE, 10'd1022);
    send_item(KIND_SAMPLE, SampleMax);
    send_item(KIND_TICK, SampleMax);
    send_item(KIND_TICK, SampleMin);
    repeat (2) begin
      send_item(KIND_SAMPLE, SampleMin);
      send_item(KIND_SAMPLE, SampleMax);
    end
    send_item(KIND_SAMPLE, SampleMin);
    send_item(KIND_TICK, SampleMin);
    send_item(KIND_SAMPLE, SampleMax);
    send_item(KIND_SAMPLE, SampleMin);
    send_item(KIND_TICK, SampleMin);
    drain();

    // climb to the top gear, downshifts impossible
    load_settings($urandom_range(100, 400), $urandom_range(600, 900), 0, 0, 0, 0);
    run_phase(150, 5);
    // both requests possible on every window
    load_settings($urandom_range(100, 400), $urandom_range(600, 900), 1, 0, 255, 0);
    run_phase(50, 5);
    // descend to gear zero
    load_settings(300, 500, 0, 255, 255, 0);
    run_phase(80, 4);

    repeat (2) begin
      load_settings($urandom_range(0, SampleMax), $urandom_range(0, SampleMax),
                    $urandom_range(0, 7), $urandom_range(0, 8), $urandom_range(0, 8),
                    $urandom_range(0, 4));
      run_phase(50, 4);
    end
    load_settings($urandom_range(0, SampleMax), $urandom_range(0, SampleMax),
                  $urandom_range(0, SampleMax), $urandom_range(0, SampleMax),
                  $urandom_range(0, SampleMax), $urandom_range(0, SampleMax));
    run_phase(50, 4);
    load_settings($urandom_range(0, 300), $urandom_range(400, SampleMax), 3,
                  $urandom_range(0, 4), $urandom_range(1, 6), $urandom_range(0, 2));
    run_phase(80, 3);

    // every sample toggles the detector
    load_settings(32'(SampleMax), 32'(SampleMin), 0, 255, 0, 0);
    repeat (40) send_item(KIND_SAMPLE, SampleW'($urandom_range(0, SampleMax)));
    send_item(KIND_TICK, SampleMin);
    drain();

    // long window
    load_settings(500, 500, 60, 0, 0, 0);
    repeat (3) begin
      send_item(KIND_SAMPLE, SampleMin);
      send_item(KIND_SAMPLE, SampleMax);
    end
    run_phase(70, 1);

    load_settings(32'(LowThresholdRst), 32'(HighThresholdRst), 2, 32'(UpLimitRst),
                  32'(DownBelowRst), 32'(DownMinRst));
    run_phase(50, 4);

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/cgs_pkg.sv
sv/cgs_cfg_regs.sv
sv/cgs_core.sv
sv/cadence_gear_shift_controller.sv
sim/cgs_result_checker.sv
sim/tb_cadence_gear_shift_controller.sv
